// ===== rtl/fir_convolution_filter_unit_defines.svh =====
// Assertion macros for the filter RTL top level.
`ifndef FIR_CONVOLUTION_FILTER_UNIT_DEFINES_SVH
`define FIR_CONVOLUTION_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FCF_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define FCF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define FCF_ASSERT_ALWAYS(label, clk, rst, cond)
`define FCF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fcf_pkg.sv =====
// Types and constants shared by the filter modules.
`timescale 1ns / 1ps
package fcf_pkg;

  localparam int DEFAULT_MAX_TAPS = 1024;
  localparam int OP_W = 2;
  localparam int TAP_INDEX_W = 10;
  localparam int TAP_COUNT_W = 11;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS = 15;
  localparam int OUT_MAX = 32767;
  localparam int OUT_NEG_MAG = 32768;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]               op;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]      coefficient;
    logic signed [SAMPLE_W-1:0]    sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic rd_v;
    logic live;
  } mac_ctl_t;

endpackage

// ===== rtl/fcf_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module fcf_ram #(
  parameter int DEPTH = fcf_pkg::DEFAULT_MAX_TAPS,
  parameter int AW = $clog2(DEPTH),
  parameter int DW = fcf_pkg::SAMPLE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcf_mac.sv =====
// Multiply-accumulate datapath with truncation and saturation of the sum.
`timescale 1ns / 1ps
module fcf_mac #(
  parameter int ACC_W = 45
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fcf_pkg::mac_ctl_t                    ctl,
  input  logic signed [fcf_pkg::COEF_W-1:0]    coef,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0]  hist,
  output logic                                 busy,
  output fcf_pkg::out_item_t                   result
);

  localparam int QW = ACC_W - fcf_pkg::FRAC_BITS;

  logic                               prod_v;
  logic signed [fcf_pkg::PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]            acc;
  logic                               neg;
  logic [ACC_W-1:0]                   mag;
  logic [QW-1:0]                      q;
  logic [fcf_pkg::SAMPLE_W-1:0]       q_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_v) begin
      if (ctl.live) begin
        prod <= coef * hist;
      end else begin
        prod <= '0;
      end
    end
    if (ctl.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = prod_v;
  assign neg = acc[ACC_W-1];
  assign mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign q = mag[ACC_W-1:fcf_pkg::FRAC_BITS];
  assign q_neg = 16'd0 - q[fcf_pkg::SAMPLE_W-1:0];

  always_comb begin
    result.saturated = 1'b0;
    if (neg) begin
      if (q > QW'(fcf_pkg::OUT_NEG_MAG)) begin
        result.sample_out = 16'sh8000;
        result.saturated = 1'b1;
      end else begin
        result.sample_out = q_neg;
      end
    end else begin
      if (q > QW'(fcf_pkg::OUT_MAX)) begin
        result.sample_out = 16'sh7fff;
        result.saturated = 1'b1;
      end else begin
        result.sample_out = q[fcf_pkg::SAMPLE_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/fir_convolution_filter_unit.sv =====
// Top level of the direct-form FIR filter: sequencer, memories and MAC.
`timescale 1ns / 1ps
`include "fir_convolution_filter_unit_defines.svh"
// The item channel takes load, sample and clear items with valid and ready.
// A load item writes one coefficient, a clear item empties the sample
// history, and both finish in the cycle they are accepted. A sample item
// enters the circular history and starts a walk over the taps: one MAC reads
// one coefficient and one history entry per cycle from two synchronous RAMs
// and the next item is accepted once the result is in the output register.
// The result channel holds one filtered sample with its saturation flag in
// an output register; a stalled receiver delays only the completion of the
// following sample item. The cfg channel is always ready and sets tap_count;
// write it only while the block is idle. Reset empties the history at once
// by clearing its fill count, returns the pointer to zero and sets tap_count
// to one. Coefficients are unknown until loaded.
module fir_convolution_filter_unit #(
  parameter int MAX_TAPS = fcf_pkg::DEFAULT_MAX_TAPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  fcf_pkg::in_item_t                 item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output fcf_pkg::out_item_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcf_pkg::TAP_COUNT_W-1:0]   cfg_data
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int TCW = (CNT_W > fcf_pkg::TAP_COUNT_W) ? CNT_W : fcf_pkg::TAP_COUNT_W;
  localparam int IW = (CNT_W > fcf_pkg::TAP_INDEX_W) ? CNT_W : fcf_pkg::TAP_INDEX_W;
  localparam int ACC_W = fcf_pkg::PROD_W + CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t                             state;
  logic [fcf_pkg::TAP_COUNT_W-1:0]    tap_count;
  logic [AW-1:0]                      hptr;
  logic [AW-1:0]                      rp;
  logic [CNT_W-1:0]                   fill;
  logic [CNT_W-1:0]                   k;
  logic [CNT_W-1:0]                   taps;
  logic                               rd_v;
  logic                               rd_live;

  logic                               accept;
  logic [AW-1:0]                      pos_next;
  logic [TCW-1:0]                     tc_ext;
  logic [CNT_W-1:0]                   taps_eff;
  logic                               idx_ok;
  logic                               coef_we;
  logic                               hist_we;
  logic                               issue;
  logic                               res_load;
  logic signed [fcf_pkg::COEF_W-1:0]  coef_rd;
  logic signed [fcf_pkg::SAMPLE_W-1:0] hist_rd;
  fcf_pkg::mac_ctl_t                  mac_ctl;
  logic                               mac_busy;
  fcf_pkg::out_item_t                 mac_result;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = item_valid && item_ready;
  assign pos_next = (hptr == AW'(MAX_TAPS - 1)) ? '0 : hptr + 1'b1;
  assign tc_ext = TCW'(tap_count);
  assign taps_eff = (tc_ext > TCW'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tc_ext);
  assign idx_ok = IW'(item.tap_index) < IW'(MAX_TAPS);
  assign coef_we = accept && (item.op == fcf_pkg::OP_LOAD) && idx_ok;
  assign hist_we = accept && (item.op == fcf_pkg::OP_SAMPLE);
  assign issue = (k < taps);
  assign res_load = (state == S_DRAIN) && !rd_v && !mac_busy &&
                    (!result_valid || result_ready);

  assign mac_ctl.start = hist_we;
  assign mac_ctl.rd_v = rd_v;
  assign mac_ctl.live = rd_live;

  fcf_ram #(
    .DEPTH(MAX_TAPS),
    .AW(AW),
    .DW(fcf_pkg::COEF_W)
  ) u_coef_ram (
    .clk(clk),
    .we(coef_we),
    .waddr(AW'(item.tap_index)),
    .wdata(item.coefficient),
    .raddr(k[AW-1:0]),
    .rdata(coef_rd)
  );

  fcf_ram #(
    .DEPTH(MAX_TAPS),
    .AW(AW),
    .DW(fcf_pkg::SAMPLE_W)
  ) u_hist_ram (
    .clk(clk),
    .we(hist_we),
    .waddr(pos_next),
    .wdata(item.sample_in),
    .raddr(rp),
    .rdata(hist_rd)
  );

  fcf_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(mac_ctl),
    .coef(coef_rd),
    .hist(hist_rd),
    .busy(mac_busy),
    .result(mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap_count <= fcf_pkg::TAP_COUNT_W'(1);
      hptr <= '0;
      fill <= '0;
      rd_v <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tap_count <= cfg_data;
      end
      rd_v <= (state == S_RUN) && issue;
      if (res_load) begin
        result <= mac_result;
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.op)
              fcf_pkg::OP_SAMPLE: begin
                hptr <= pos_next;
                rp <= pos_next;
                k <= '0;
                taps <= taps_eff;
                if (fill != CNT_W'(MAX_TAPS)) begin
                  fill <= fill + 1'b1;
                end
                state <= S_RUN;
              end
              fcf_pkg::OP_CLEAR: begin
                hptr <= '0;
                fill <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          if (issue) begin
            rd_live <= (k < fill);
            k <= k + 1'b1;
            rp <= (rp == '0) ? AW'(MAX_TAPS - 1) : rp - 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FCF_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= CNT_W'(MAX_TAPS))
  `FCF_ASSERT_IMPLIES(a_idle_pipe_empty, clk, rst, state == S_IDLE, !rd_v && !mac_busy)
  `FCF_ASSERT_IMPLIES(a_tap_walk_bound, clk, rst, state != S_IDLE, k <= taps)

endmodule
